// ===== rtl/uvar_pkg.sv =====
// Shared types and constants for the up/down value with key auto-repeat.
package uvar_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned TickW  = 16;
  localparam int unsigned StepW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgMinValue       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxValue       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatInterval = 2'd2;

  // Reset values of the configuration registers
  localparam logic signed [ValueW-1:0] MinValueRst       = 16'sd0;
  localparam logic signed [ValueW-1:0] MaxValueRst       = 16'sd99;
  localparam logic        [TickW-1:0]  RepeatIntervalRst = 16'd200;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  typedef struct packed {
    logic signed [ValueW-1:0] min_value;
    logic signed [ValueW-1:0] max_value;
    logic        [TickW-1:0]  repeat_interval;
  } uvar_cfg_t;

endpackage

// ===== rtl/uvar_cfg.sv =====
// Configuration register file: clamp bounds and repeat interval.
module uvar_cfg import uvar_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  output uvar_cfg_t          cfg_o
);

  uvar_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_value       <= MinValueRst;
      cfg_q.max_value       <= MaxValueRst;
      cfg_q.repeat_interval <= RepeatIntervalRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMinValue:       cfg_q.min_value       <= $signed(cfg_data_i);
        CfgMaxValue:       cfg_q.max_value       <= $signed(cfg_data_i);
        CfgRepeatInterval: cfg_q.repeat_interval <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/uvar_key.sv =====
// One key: edge detect, elapsed-tick counter and auto-repeat step count.
module uvar_key import uvar_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             level_i,
  input  logic [TickW-1:0] interval_i,
  output logic [StepW-1:0] steps_o
);

  logic             held_q, held_d;
  logic [TickW-1:0] elapsed_q, elapsed_d;
  logic [TickW-1:0] elapsed_inc;
  logic             press, repeat_hit;

  always_comb begin
    elapsed_inc = (elapsed_q == TickMax) ? elapsed_q : elapsed_q + TickW'(1);
    press       = level_i && !held_q;
    held_d      = level_i;
    elapsed_d   = press ? '0 : elapsed_inc;
    repeat_hit  = held_d && (elapsed_d >= interval_i);
    if (repeat_hit) begin
      elapsed_d = '0;
    end
    steps_o = StepW'(press) + StepW'(repeat_hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 1'b0;
      elapsed_q <= '0;
    end else if (advance_i) begin
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Two steps in one tick only happen with a zero interval
  a_double_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (steps_o == StepW'(2)) |-> (interval_i == '0))
    else $error("double step with nonzero repeat interval");

endmodule

// ===== rtl/updown_value_with_autorepeat_top.sv =====
// Top level: input word register, value update with clamp, result register.
//
// Up/down value with key auto-repeat. Each input word is one millisecond tick
// carrying the debounced plus/minus key levels and a clear request; each tick
// yields exactly one result word, the clamped value after that tick. A key's
// press steps the value once; while held, another step comes every
// repeat_interval ticks (a zero interval steps on every held tick, twice on
// the press tick). Plus is applied before minus, then the sum is clamped to
// [min_value, max_value]; with inverted bounds a value below min_value goes to
// min_value and anything else to max_value. Clear zeroes the value before the
// tick's steps. Throughput: one word per clock while results are taken. An
// accepted word waits in the input register and is processed out of it once
// the result register is free or being taken; the result is then registered
// in the result register. The key state, value and result register all
// update together when the word is processed. The input register
// frees whenever the result register is empty or being taken, so a stalled
// result blocks the input only once the input register also holds a word.
// Configuration writes are always ready and take effect at once; write them
// only while idle.
module updown_value_with_autorepeat_top import uvar_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // tick words
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     plus_level_i,
  input  logic                     minus_level_i,
  input  logic                     clear_value_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] current_value_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [TickW-1:0]         cfg_data_i
);

  uvar_cfg_t cfg;

  // input register
  logic in_valid_q;
  logic plus_q, minus_q, clear_q;
  // value and result register
  logic                     out_valid_q;
  logic signed [ValueW-1:0] count_q, count_d;
  logic signed [ValueW-1:0] result_q;

  logic             advance;
  logic [StepW-1:0] plus_steps, minus_steps;
  logic signed [ValueW:0] base, sum, lo, hi;

  // Process the held word when the result slot is free or emptying
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  uvar_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uvar_key u_plus (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .level_i    (plus_q),
    .interval_i (cfg.repeat_interval),
    .steps_o    (plus_steps)
  );

  uvar_key u_minus (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .level_i    (minus_q),
    .interval_i (cfg.repeat_interval),
    .steps_o    (minus_steps)
  );

  // 17-bit sum holds value +/- 2 without wrap
  always_comb begin
    base = clear_q ? '0 : (ValueW+1)'(count_q);
    sum  = base + $signed({{(ValueW+1-StepW){1'b0}}, plus_steps})
                - $signed({{(ValueW+1-StepW){1'b0}}, minus_steps});
    lo   = (ValueW+1)'(cfg.min_value);
    hi   = (ValueW+1)'(cfg.max_value);
    if (sum < lo) begin
      count_d = cfg.min_value;
    end else if (sum > hi) begin
      count_d = cfg.max_value;
    end else begin
      count_d = sum[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      plus_q  <= plus_level_i;
      minus_q <= minus_level_i;
      clear_q <= clear_value_i;
    end
    if (advance) begin
      result_q <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = result_q;

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while word stuck behind stalled result");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word produced no result");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> (in_ready_o && !advance))
    else $error("empty input register not ready or advancing");

endmodule
